// File: rtl/core/cfp_pkg.sv
// shared types and constants of the cell frame prefilter
package cfp_pkg;

	// previous-frame store geometry
	localparam int MAX_CELLS = 4096;
	localparam int POS_W     = $clog2(MAX_CELLS);
	localparam int CNT_W     = POS_W + 1;

	// configuration register widths
	localparam int QUANT_W    = 3;
	localparam int THRESH_W   = 8;
	localparam int INTERVAL_W = 16;
	localparam int FRAME_W    = 13;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// largest usable quantisation shift
	localparam logic [QUANT_W-1:0] QUANT_MAX = 3'd4;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUANT_BITS        = 2'd0,
		CFG_SNAP_THRESHOLD    = 2'd1,
		CFG_KEYFRAME_INTERVAL = 2'd2,
		CFG_FRAME_CELLS       = 2'd3
	} cfg_index_t;

	// one character cell, glyph in the lowest byte
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] glyph;
	} cell_t;

	// per-cell control worked out when the cell is taken in
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             hw_ok;
		logic             snap_en;
		logic             key;
		logic             delta;
		logic             last;
	} item_ctrl_t;

endpackage

// File: rtl/core/cfp_ram.sv
// generic single-write, single-read ram with registered read data
module cfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and read-first registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/cfp_ctrl.sv
// configuration registers and frame position, phase and fill tracking
module cfp_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                         accept,
	output cfp_pkg::item_ctrl_t          item_ctrl,
	output logic [7:0]                   color_mask,
	output logic [cfp_pkg::THRESH_W-1:0] snap_threshold
);
	import cfp_pkg::*;

	logic [QUANT_W-1:0]    quant_bits_q;
	logic [THRESH_W-1:0]   snap_threshold_q;
	logic [INTERVAL_W-1:0] keyframe_interval_q;
	logic [FRAME_W-1:0]    frame_cells_q;

	logic [POS_W-1:0]      cell_position_q;
	logic                  seen_frame_q;
	logic [INTERVAL_W-1:0] keyframe_phase_q;
	logic [CNT_W-1:0]      fill_q;

	logic [QUANT_W-1:0]    shift;
	logic [CNT_W-1:0]      frame_len;
	logic [CNT_W-1:0]      pos_next;
	logic [INTERVAL_W:0]   phase_next;
	logic                  key;
	logic                  last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_bits_q        <= '0;
			snap_threshold_q    <= '0;
			keyframe_interval_q <= '0;
			frame_cells_q       <= FRAME_W'(MAX_CELLS);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_QUANT_BITS:        quant_bits_q        <= cfg_wdata[QUANT_W-1:0];
				CFG_SNAP_THRESHOLD:    snap_threshold_q    <= cfg_wdata[THRESH_W-1:0];
				CFG_KEYFRAME_INTERVAL: keyframe_interval_q <= cfg_wdata[INTERVAL_W-1:0];
				CFG_FRAME_CELLS:       frame_cells_q       <= cfg_wdata[FRAME_W-1:0];
			endcase
		end
	end

	// color mask, out-of-range shifts disable quantization
	assign shift      = (quant_bits_q <= QUANT_MAX) ? quant_bits_q : '0;
	assign color_mask = 8'hFF << shift;
	assign snap_threshold = snap_threshold_q;

	// frame length clamped to one..store depth
	always_comb begin
		priority if (frame_cells_q == '0) begin
			frame_len = CNT_W'(1);
		end else if (CNT_W'(frame_cells_q) > CNT_W'(MAX_CELLS)) begin
			frame_len = CNT_W'(MAX_CELLS);
		end else begin
			frame_len = CNT_W'(frame_cells_q);
		end
	end

	// per-cell flags
	assign pos_next   = {1'b0, cell_position_q} + CNT_W'(1);
	assign last       = pos_next >= frame_len;
	assign key        = (keyframe_interval_q != '0) && (keyframe_phase_q == '0);
	assign phase_next = {1'b0, keyframe_phase_q} + (INTERVAL_W+1)'(1);

	assign item_ctrl.pos     = cell_position_q;
	assign item_ctrl.hw_ok   = {1'b0, cell_position_q} < fill_q;
	assign item_ctrl.snap_en = seen_frame_q && (snap_threshold_q != '0);
	assign item_ctrl.key     = key;
	assign item_ctrl.delta   = seen_frame_q && !key;
	assign item_ctrl.last    = last;

	// position and store fill advance on accepted cells, the keyframe phase on each frame's last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_position_q  <= '0;
			seen_frame_q     <= 1'b0;
			keyframe_phase_q <= '0;
			fill_q           <= '0;
		end else if (accept) begin
			if (pos_next > fill_q) begin
				fill_q <= pos_next;
			end
			if (last) begin
				cell_position_q <= '0;
				seen_frame_q    <= 1'b1;
				if (phase_next >= {1'b0, keyframe_interval_q}) begin
					keyframe_phase_q <= '0;
				end else begin
					keyframe_phase_q <= phase_next[INTERVAL_W-1:0];
				end
			end else begin
				cell_position_q <= pos_next[POS_W-1:0];
			end
		end
	end

endmodule

// File: rtl/core/cell_frame_prefilter_core.sv
// top level of the cell frame prefilter: three-stage snap pipeline around the cell store
// an input transfer passes stage one and stage two before its result reaches the output register
// throughput: one cell per cycle unless the output stalls; the store does one read and one write per cycle
// back-to-back cells at the same position are served by forwarding the pending write
// reset clears all control state at once; store entries never written read as zero
// through a fill mark, so no clearing pass is needed after reset
module cell_frame_prefilter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // cell_char, cell_red, cell_green, cell_blue
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // out_char, out_red, out_green, out_blue
	output logic [1:0]                     m_tuser,   // is_keyframe, delta_allowed
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [cfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cfp_pkg::*;

	item_ctrl_t          item_ctrl;
	logic [7:0]          color_mask;
	logic [THRESH_W-1:0] thresh;
	logic                accept;

	logic                ready_s1, ready_s2, ready_s3;
	logic                adv_s1, adv_s2;

	logic                valid_s1, valid_s2, valid_s3;
	cell_t               cell_s1, cell_s2, cell_s3;
	item_ctrl_t          ctrl_s1, ctrl_s2;
	logic                fwd_v_s1;
	cell_t               fwd_d_s1;
	cell_t               stored_s2;
	logic                key_s3, delta_s3, last_s3;

	cell_t               in_cell;
	cell_t               ram_rdata;
	cell_t               stored_s1;
	cell_t               final_s2;
	logic [7:0]          diff_r, diff_g, diff_b;
	logic                hit_s2;
	logic                ram_we;

	cfp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.accept         (accept),
		.item_ctrl      (item_ctrl),
		.color_mask     (color_mask),
		.snap_threshold (thresh)
	);

	// per-stage handshake
	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv_s2   = valid_s2 && ready_s3;
	assign adv_s1   = valid_s1 && ready_s2;
	assign s_tready = ready_s1;
	assign accept   = s_tvalid && ready_s1;

	// quantize color on entry
	assign in_cell.glyph = s_tdata[7:0];
	assign in_cell.red   = s_tdata[15:8] & color_mask;
	assign in_cell.green = s_tdata[23:16] & color_mask;
	assign in_cell.blue  = s_tdata[31:24] & color_mask;

	// previous-frame store, written when a cell leaves stage two
	assign ram_we = adv_s2;

	cfp_ram #(
		.WIDTH ($bits(cell_t)),
		.DEPTH (MAX_CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctrl_s2.pos),
		.wdata (final_s2),
		.re    (accept),
		.raddr (item_ctrl.pos),
		.rdata (ram_rdata)
	);

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_v_s1 <= ram_we && (ctrl_s2.pos == item_ctrl.pos);
			end else begin
				if (adv_s1) begin
					valid_s1 <= 1'b0;
				end
				if (ram_we && (ctrl_s2.pos == ctrl_s1.pos)) begin
					fwd_v_s1 <= 1'b1;
				end
			end
		end
	end

	// stage one payload and forwarded write capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1  <= in_cell;
			ctrl_s1  <= item_ctrl;
			fwd_d_s1 <= final_s2;
		end else if (ram_we && (ctrl_s2.pos == ctrl_s1.pos)) begin
			fwd_d_s1 <= final_s2;
		end
	end

	// stored cell: write in this cycle, then captured write, then store or reset value
	always_comb begin
		priority if (ram_we && (ctrl_s2.pos == ctrl_s1.pos)) begin
			stored_s1 = final_s2;
		end else if (fwd_v_s1) begin
			stored_s1 = fwd_d_s1;
		end else if (ctrl_s1.hw_ok) begin
			stored_s1 = ram_rdata;
		end else begin
			stored_s1 = '0;
		end
	end

	// stage two registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cell_s2   <= cell_s1;
			ctrl_s2   <= ctrl_s1;
			stored_s2 <= stored_s1;
		end
	end

	// snap test against the stored cell
	assign diff_r = (cell_s2.red > stored_s2.red) ? cell_s2.red - stored_s2.red
	                                              : stored_s2.red - cell_s2.red;
	assign diff_g = (cell_s2.green > stored_s2.green) ? cell_s2.green - stored_s2.green
	                                                  : stored_s2.green - cell_s2.green;
	assign diff_b = (cell_s2.blue > stored_s2.blue) ? cell_s2.blue - stored_s2.blue
	                                                : stored_s2.blue - cell_s2.blue;
	assign hit_s2 = ctrl_s2.snap_en && (cell_s2.glyph == stored_s2.glyph) &&
	                (diff_r <= thresh) && (diff_g <= thresh) && (diff_b <= thresh);
	assign final_s2 = hit_s2 ? stored_s2 : cell_s2;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cell_s3  <= final_s2;
			key_s3   <= ctrl_s2.key;
			delta_s3 <= ctrl_s2.delta;
			last_s3  <= ctrl_s2.last;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = cell_s3;
	assign m_tuser  = {delta_s3, key_s3};
	assign m_tlast  = last_s3;

endmodule

// File: rtl/core/cfp_checker.sv
// port-level checks of the cell frame prefilter and their binding
module cfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its contents
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a keyframe is never also a delta frame
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("keyframe and delta both set");

	// with the output free the pipeline always takes a cell
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with output free");

endmodule

bind cell_frame_prefilter_core cfp_checker u_cfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
